// ----- rtl/fsse_pkg.sv -----
// Shared types, codes and constants of the formant speech sample engine.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none
package fsse_pkg;

	localparam int WAVE_DEPTH     = 1024;
	localparam int WAVE_AW        = $clog2(WAVE_DEPTH);
	localparam int PHASE_W        = 26;
	localparam int NUM_RES        = 7;
	localparam int RES_AW         = $clog2(NUM_RES);
	localparam int FIELDS_PER_RES = 6;

	// Opcodes carried in the low bits of the input tuser.
	localparam logic [1:0] OPC_SAMPLE = 2'd0;
	localparam logic [1:0] OPC_PARAM  = 2'd1;
	localparam logic [1:0] OPC_TABLE  = 2'd2;

	// Table selectors.
	localparam logic [1:0] TSEL_WAVE_A = 2'd0;
	localparam logic [1:0] TSEL_WAVE_B = 2'd1;
	localparam logic [1:0] TSEL_CURVE  = 2'd2;

	// Parameter word numbers of the scalar state.
	localparam logic [5:0] PW_PHASE_ACC = 6'd0;
	localparam logic [5:0] PW_PHASE_INC = 6'd1;
	localparam logic [5:0] PW_GAIN_A    = 6'd2;
	localparam logic [5:0] PW_GAIN_B    = 6'd3;
	localparam logic [5:0] PW_VOICE_LVL = 6'd4;
	localparam logic [5:0] PW_VOICE_SLP = 6'd5;
	localparam logic [5:0] PW_ASP_NEG   = 6'd6;
	localparam logic [5:0] PW_ASP_POS   = 6'd7;
	localparam logic [5:0] PW_FRIC_NEG  = 6'd8;
	localparam logic [5:0] PW_FRIC_POS  = 6'd9;
	localparam logic [5:0] PW_SHAPE     = 6'd10;
	localparam logic [5:0] PW_LAST      = 6'd11;
	localparam int         PW_RES_BASE  = 12;

	// Resonator numbers that change the control flow or the coefficient sweep of the sequence.
	localparam logic [RES_AW-1:0] RES_SOURCE = 3'd0;
	localparam logic [RES_AW-1:0] RES_F1     = 3'd2;
	localparam logic [RES_AW-1:0] RES_F3     = 3'd3;
	localparam logic [RES_AW-1:0] RES_F2     = 3'd5;
	localparam logic [RES_AW-1:0] RES_FRIC   = 3'd6;

	localparam logic [7:0] CURVE_OFFSET = 8'd128;

	typedef enum logic [2:0] {
		RF_HIST1,
		RF_HIST2,
		RF_A_LVL,
		RF_A_SLP,
		RF_B_LVL,
		RF_B_SLP
	} res_field_t;

	typedef struct packed {
		logic              hit;
		logic [RES_AW-1:0] k;
		res_field_t        f;
	} res_sel_t;

	typedef enum logic [4:0] {
		DP_NONE,
		DP_PHASE,
		DP_MUL_A,
		DP_MUL_B,
		DP_SRC,
		DP_VOICE,
		DP_VOICED,
		DP_RES_B,
		DP_RES_A,
		DP_RES_OUT,
		DP_ASP_MUL,
		DP_ASP_ADD,
		DP_NB_IN,
		DP_SHAPE_MUL,
		DP_NOISE,
		DP_FRIC_MUL,
		DP_MIX
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PHASE,
		ST_MUL_A,
		ST_MUL_B,
		ST_SRC,
		ST_VOICE,
		ST_VOICED,
		ST_RES_B,
		ST_RES_A,
		ST_RES_OUT,
		ST_ASP_MUL,
		ST_ASP_ADD,
		ST_NB_IN,
		ST_SHAPE_MUL,
		ST_NOISE,
		ST_FRIC_MUL,
		ST_MIX,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              wr_param;
		logic              wr_table;
		logic              latch;
		dp_op_t            op;
		logic [RES_AW-1:0] res_k;
		logic              res_step;
		logic              load_out;
	} dp_cmd_t;

	// Maps a parameter word number onto a resonator and one of its fields.
	function automatic res_sel_t res_decode(input logic [5:0] idx);
		res_sel_t   r;
		logic [5:0] base;
		logic [5:0] off;
		r.hit = 1'b0;
		r.k   = '0;
		r.f   = RF_HIST1;
		for (int k = 0; k < NUM_RES; k++) begin
			base = 6'(PW_RES_BASE + FIELDS_PER_RES * k);
			off  = idx - base;
			if (idx >= base && off < 6'(FIELDS_PER_RES)) begin
				r.hit = 1'b1;
				r.k   = RES_AW'(k);
				r.f   = res_field_t'(off[2:0]);
			end
		end
		return r;
	endfunction

	// Source, F1, F3 and F2 sweep their coefficients every sample.
	function automatic logic res_steps(input logic [RES_AW-1:0] k);
		return (k == RES_SOURCE) || (k == RES_F1) || (k == RES_F3) || (k == RES_F2);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/fsse_ctrl.sv -----
// Sequencer of the formant speech sample engine: walks one sample through
// the shared multiplier datapath. Depends on fsse_pkg.
`default_nettype none
module fsse_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	input  wire logic [1:0]                        s_opcode,
	output logic                                   s_tready,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output fsse_pkg::dp_cmd_t                      cmd
);

	fsse_pkg::state_t                state_q, state_nxt;
	logic [fsse_pkg::RES_AW-1:0]     res_q;
	logic                            out_valid_q;
	logic                            accept;
	logic                            emit_fire;

	assign s_tready  = (state_q == fsse_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign emit_fire = (state_q == fsse_pkg::ST_EMIT) && (!out_valid_q || m_tready);
	assign m_tvalid  = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fsse_pkg::ST_IDLE: begin
				if (accept && s_opcode == fsse_pkg::OPC_SAMPLE) state_nxt = fsse_pkg::ST_PHASE;
			end
			fsse_pkg::ST_PHASE:     state_nxt = fsse_pkg::ST_MUL_A;
			fsse_pkg::ST_MUL_A:     state_nxt = fsse_pkg::ST_MUL_B;
			fsse_pkg::ST_MUL_B:     state_nxt = fsse_pkg::ST_SRC;
			fsse_pkg::ST_SRC:       state_nxt = fsse_pkg::ST_VOICE;
			fsse_pkg::ST_VOICE:     state_nxt = fsse_pkg::ST_VOICED;
			fsse_pkg::ST_VOICED:    state_nxt = fsse_pkg::ST_RES_B;
			fsse_pkg::ST_RES_B:     state_nxt = fsse_pkg::ST_RES_A;
			fsse_pkg::ST_RES_A:     state_nxt = fsse_pkg::ST_RES_OUT;
			fsse_pkg::ST_RES_OUT: begin
				priority if (res_q == fsse_pkg::RES_SOURCE) state_nxt = fsse_pkg::ST_ASP_MUL;
				else if (res_q == fsse_pkg::RES_F2)        state_nxt = fsse_pkg::ST_NB_IN;
				else if (res_q == fsse_pkg::RES_FRIC)      state_nxt = fsse_pkg::ST_SHAPE_MUL;
				else                                       state_nxt = fsse_pkg::ST_RES_B;
			end
			fsse_pkg::ST_ASP_MUL:   state_nxt = fsse_pkg::ST_ASP_ADD;
			fsse_pkg::ST_ASP_ADD:   state_nxt = fsse_pkg::ST_RES_B;
			fsse_pkg::ST_NB_IN:     state_nxt = fsse_pkg::ST_RES_B;
			fsse_pkg::ST_SHAPE_MUL: state_nxt = fsse_pkg::ST_NOISE;
			fsse_pkg::ST_NOISE:     state_nxt = fsse_pkg::ST_FRIC_MUL;
			fsse_pkg::ST_FRIC_MUL:  state_nxt = fsse_pkg::ST_MIX;
			fsse_pkg::ST_MIX:       state_nxt = fsse_pkg::ST_EMIT;
			fsse_pkg::ST_EMIT: begin
				if (emit_fire) state_nxt = fsse_pkg::ST_IDLE;
			end
			default:                state_nxt = fsse_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.op       = fsse_pkg::DP_NONE;
		cmd.wr_param = accept && (s_opcode == fsse_pkg::OPC_PARAM);
		cmd.wr_table = accept && (s_opcode == fsse_pkg::OPC_TABLE);
		cmd.latch    = accept && (s_opcode == fsse_pkg::OPC_SAMPLE);
		cmd.res_k    = res_q;
		cmd.res_step = fsse_pkg::res_steps(res_q);
		cmd.load_out = emit_fire;
		unique case (state_q)
			fsse_pkg::ST_PHASE:     cmd.op = fsse_pkg::DP_PHASE;
			fsse_pkg::ST_MUL_A:     cmd.op = fsse_pkg::DP_MUL_A;
			fsse_pkg::ST_MUL_B:     cmd.op = fsse_pkg::DP_MUL_B;
			fsse_pkg::ST_SRC:       cmd.op = fsse_pkg::DP_SRC;
			fsse_pkg::ST_VOICE:     cmd.op = fsse_pkg::DP_VOICE;
			fsse_pkg::ST_VOICED:    cmd.op = fsse_pkg::DP_VOICED;
			fsse_pkg::ST_RES_B:     cmd.op = fsse_pkg::DP_RES_B;
			fsse_pkg::ST_RES_A:     cmd.op = fsse_pkg::DP_RES_A;
			fsse_pkg::ST_RES_OUT:   cmd.op = fsse_pkg::DP_RES_OUT;
			fsse_pkg::ST_ASP_MUL:   cmd.op = fsse_pkg::DP_ASP_MUL;
			fsse_pkg::ST_ASP_ADD:   cmd.op = fsse_pkg::DP_ASP_ADD;
			fsse_pkg::ST_NB_IN:     cmd.op = fsse_pkg::DP_NB_IN;
			fsse_pkg::ST_SHAPE_MUL: cmd.op = fsse_pkg::DP_SHAPE_MUL;
			fsse_pkg::ST_NOISE:     cmd.op = fsse_pkg::DP_NOISE;
			fsse_pkg::ST_FRIC_MUL:  cmd.op = fsse_pkg::DP_FRIC_MUL;
			fsse_pkg::ST_MIX:       cmd.op = fsse_pkg::DP_MIX;
			default:                cmd.op = fsse_pkg::DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsse_pkg::ST_IDLE;
			res_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == fsse_pkg::ST_VOICED) res_q <= fsse_pkg::RES_SOURCE;
			else if (state_q == fsse_pkg::ST_RES_OUT) res_q <= res_q + 1'b1;
			if (emit_fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/fsse_dp.sv -----
// Datapath of the formant speech sample engine: state words, waveform and
// curve memories, one shared 16x16 multiplier. Depends on fsse_pkg.
`default_nettype none
module fsse_dp #(
	parameter int LEVEL_LIMIT = 200
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire fsse_pkg::dp_cmd_t       cmd,
	input  wire logic signed [15:0]      noise_a,
	input  wire logic signed [15:0]      noise_b,
	input  wire logic [5:0]              param_index,
	input  wire logic [31:0]             param_value,
	input  wire logic [1:0]              table_select,
	input  wire logic [9:0]              table_address,
	input  wire logic signed [15:0]      table_value,
	output logic [7:0]                   audio_byte
);

	localparam int CURVE_DEPTH = 2 * LEVEL_LIMIT + 1;
	localparam int CURVE_AW    = $clog2(CURVE_DEPTH);
	localparam logic signed [10:0] LIM_P = 11'(LEVEL_LIMIT);
	localparam logic signed [10:0] LIM_N = 11'(-LEVEL_LIMIT);

	// Architectural scalar state.
	logic [fsse_pkg::PHASE_W-1:0] phase_q, inc_q, phase_nxt;
	logic signed [15:0]           gain_a_q, gain_b_q;
	logic [31:0]                  voice_lvl_q, voice_slp_q;
	logic signed [15:0]           asp_neg_q, asp_pos_q, fric_neg_q, fric_pos_q;
	logic signed [15:0]           shape_q, last_q;

	// Resonator state.
	logic signed [15:0] hist1_q [fsse_pkg::NUM_RES];
	logic signed [15:0] hist2_q [fsse_pkg::NUM_RES];
	logic [31:0]        a_lvl_q [fsse_pkg::NUM_RES];
	logic [31:0]        a_slp_q [fsse_pkg::NUM_RES];
	logic [31:0]        b_lvl_q [fsse_pkg::NUM_RES];
	logic [31:0]        b_slp_q [fsse_pkg::NUM_RES];

	// Memories.
	logic [15:0] wave_a_mem [fsse_pkg::WAVE_DEPTH];
	logic [15:0] wave_b_mem [fsse_pkg::WAVE_DEPTH];
	logic [7:0]  curve_mem  [CURVE_DEPTH];

	// Working registers.
	logic signed [15:0] na_q, nb_q, x_q, t_q, sig_q;
	logic signed [15:0] asp_sel_q, fric_sel_q;
	logic signed [15:0] wave_a_rd_q, wave_b_rd_q;
	logic [7:0]         curve_rd_q, audio_q;
	logic signed [31:0] prod_q;

	logic signed [15:0] mul_a, mul_b;
	logic signed [15:0] p15, p14;
	logic signed [15:0] h1, h2, d1, d2, res_out, voiced, vdiff, shaped, mixed;
	logic signed [10:0] level, level_c;
	logic [10:0]        curve_idx;
	fsse_pkg::res_sel_t rsel;
	logic [fsse_pkg::WAVE_AW-1:0] wave_idx;

	assign phase_nxt = phase_q + inc_q;
	assign wave_idx  = phase_nxt[fsse_pkg::PHASE_W-1 -: fsse_pkg::WAVE_AW];
	assign p15       = prod_q[30:15];
	assign p14       = prod_q[29:14];
	assign h1        = hist1_q[cmd.res_k];
	assign h2        = hist2_q[cmd.res_k];
	assign d1        = h1 - x_q;
	assign d2        = h2 - x_q;
	assign res_out   = x_q - t_q + p14;
	assign voiced    = p15;
	assign vdiff     = voiced - last_q;
	assign shaped    = {prod_q[27:15], prod_q[15:13]};
	assign mixed     = sig_q + shaped;
	assign level     = mixed[15:5];
	assign curve_idx = level_c + LIM_P;
	assign rsel      = fsse_pkg::res_decode(param_index);
	assign audio_byte = audio_q;

	always_comb begin
		priority if (level < LIM_N) level_c = LIM_N;
		else if (level > LIM_P)     level_c = LIM_P;
		else                        level_c = level;
	end

	// Operand selection of the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			fsse_pkg::DP_MUL_A: begin
				mul_a = wave_a_rd_q;
				mul_b = gain_a_q;
			end
			fsse_pkg::DP_MUL_B: begin
				mul_a = wave_b_rd_q;
				mul_b = gain_b_q;
			end
			fsse_pkg::DP_VOICE: begin
				mul_a = t_q;
				mul_b = voice_lvl_q[31:16];
			end
			fsse_pkg::DP_RES_B: begin
				mul_a = d2;
				mul_b = b_lvl_q[cmd.res_k][31:16];
			end
			fsse_pkg::DP_RES_A: begin
				mul_a = d1;
				mul_b = a_lvl_q[cmd.res_k][31:16];
			end
			fsse_pkg::DP_ASP_MUL: begin
				mul_a = na_q;
				mul_b = asp_sel_q;
			end
			fsse_pkg::DP_SHAPE_MUL: begin
				mul_a = x_q;
				mul_b = shape_q;
			end
			fsse_pkg::DP_FRIC_MUL: begin
				mul_a = t_q;
				mul_b = fric_sel_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.latch) begin
			na_q <= noise_a;
			nb_q <= noise_b;
		end
		unique case (cmd.op)
			fsse_pkg::DP_MUL_B: t_q <= p15;
			fsse_pkg::DP_SRC:   t_q <= t_q + p15;
			fsse_pkg::DP_VOICED: begin
				asp_sel_q  <= voiced[15] ? asp_neg_q : asp_pos_q;
				fric_sel_q <= voiced[15] ? fric_neg_q : fric_pos_q;
				x_q        <= {vdiff[14:0], 1'b0};
			end
			fsse_pkg::DP_RES_A:   t_q <= p15;
			fsse_pkg::DP_RES_OUT: x_q <= res_out;
			fsse_pkg::DP_ASP_ADD: x_q <= x_q + p15;
			fsse_pkg::DP_NB_IN: begin
				sig_q <= x_q;
				x_q   <= nb_q >>> 2;
			end
			fsse_pkg::DP_NOISE: t_q <= p15 - (nb_q >>> 7);
			default: ;
		endcase
		if (cmd.load_out) audio_q <= curve_rd_q + fsse_pkg::CURVE_OFFSET;
	end

	// Scalar state: parameter writes and per-sample updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			inc_q       <= '0;
			gain_a_q    <= '0;
			gain_b_q    <= '0;
			voice_lvl_q <= '0;
			voice_slp_q <= '0;
			asp_neg_q   <= '0;
			asp_pos_q   <= '0;
			fric_neg_q  <= '0;
			fric_pos_q  <= '0;
			shape_q     <= '0;
			last_q      <= '0;
		end else if (cmd.wr_param) begin
			unique case (param_index)
				fsse_pkg::PW_PHASE_ACC: phase_q     <= param_value[fsse_pkg::PHASE_W-1:0];
				fsse_pkg::PW_PHASE_INC: inc_q       <= param_value[fsse_pkg::PHASE_W-1:0];
				fsse_pkg::PW_GAIN_A:    gain_a_q    <= param_value[15:0];
				fsse_pkg::PW_GAIN_B:    gain_b_q    <= param_value[15:0];
				fsse_pkg::PW_VOICE_LVL: voice_lvl_q <= param_value;
				fsse_pkg::PW_VOICE_SLP: voice_slp_q <= param_value;
				fsse_pkg::PW_ASP_NEG:   asp_neg_q   <= param_value[15:0];
				fsse_pkg::PW_ASP_POS:   asp_pos_q   <= param_value[15:0];
				fsse_pkg::PW_FRIC_NEG:  fric_neg_q  <= param_value[15:0];
				fsse_pkg::PW_FRIC_POS:  fric_pos_q  <= param_value[15:0];
				fsse_pkg::PW_SHAPE:     shape_q     <= param_value[15:0];
				fsse_pkg::PW_LAST:      last_q      <= param_value[15:0];
				default: ;
			endcase
		end else begin
			if (cmd.op == fsse_pkg::DP_PHASE) phase_q <= phase_nxt;
			if (cmd.op == fsse_pkg::DP_VOICE) voice_lvl_q <= voice_lvl_q + voice_slp_q;
			if (cmd.op == fsse_pkg::DP_VOICED) last_q <= voiced;
		end
	end

	// Resonator state: parameter writes and the update after each filter pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < fsse_pkg::NUM_RES; k++) begin
				hist1_q[k] <= '0;
				hist2_q[k] <= '0;
				a_lvl_q[k] <= '0;
				a_slp_q[k] <= '0;
				b_lvl_q[k] <= '0;
				b_slp_q[k] <= '0;
			end
		end else if (cmd.wr_param) begin
			if (rsel.hit) begin
				unique case (rsel.f)
					fsse_pkg::RF_HIST1: hist1_q[rsel.k] <= param_value[15:0];
					fsse_pkg::RF_HIST2: hist2_q[rsel.k] <= param_value[15:0];
					fsse_pkg::RF_A_LVL: a_lvl_q[rsel.k] <= param_value;
					fsse_pkg::RF_A_SLP: a_slp_q[rsel.k] <= param_value;
					fsse_pkg::RF_B_LVL: b_lvl_q[rsel.k] <= param_value;
					fsse_pkg::RF_B_SLP: b_slp_q[rsel.k] <= param_value;
					default: ;
				endcase
			end
		end else if (cmd.op == fsse_pkg::DP_RES_OUT) begin
			hist2_q[cmd.res_k] <= h1;
			hist1_q[cmd.res_k] <= res_out;
			if (cmd.res_step) begin
				a_lvl_q[cmd.res_k] <= a_lvl_q[cmd.res_k] + a_slp_q[cmd.res_k];
				b_lvl_q[cmd.res_k] <= b_lvl_q[cmd.res_k] + b_slp_q[cmd.res_k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_table && table_select == fsse_pkg::TSEL_WAVE_A) begin
			wave_a_mem[table_address[fsse_pkg::WAVE_AW-1:0]] <= table_value;
		end
		if (cmd.op == fsse_pkg::DP_PHASE) wave_a_rd_q <= wave_a_mem[wave_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_table && table_select == fsse_pkg::TSEL_WAVE_B) begin
			wave_b_mem[table_address[fsse_pkg::WAVE_AW-1:0]] <= table_value;
		end
		if (cmd.op == fsse_pkg::DP_PHASE) wave_b_rd_q <= wave_b_mem[wave_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_table && table_select == fsse_pkg::TSEL_CURVE
				&& table_address < 10'(CURVE_DEPTH)) begin
			curve_mem[table_address[CURVE_AW-1:0]] <= table_value[7:0];
		end
		if (cmd.op == fsse_pkg::DP_MIX) curve_rd_q <= curve_mem[curve_idx[CURVE_AW-1:0]];
	end

endmodule
`default_nettype wire

// ----- rtl/formant_speech_sample_engine_core.sv -----
// Top level of the formant speech sample engine: stream ports, the
// sequencer and the datapath. Depends on fsse_pkg, fsse_ctrl and fsse_dp.
//
//   Channel  Dir  Beat contents
//   s_*      in   tuser: opcode, table_select; tdata: noise, parameter and table fields
//   m_*      out  tdata: audio_byte
//
// A sample beat keeps the engine busy from acceptance until it has walked
// through its whole sequence of states, since the single shared 16x16
// multiplier takes the products of the sample one after another. Parameter
// and table write beats leave the engine idle. Reset clears the state words;
// the waveform and curve tables are undefined until written. The finished
// byte sits in an output register, so the input takes new beats while a
// result waits; a stalled output holds only the final step of the next sample.
`default_nettype none
module formant_speech_sample_engine_core #(
	parameter int LEVEL_LIMIT = 200
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// From bit 0: noise_a[15:0], noise_b[15:0], param_index[5:0],
	// param_value[31:0], table_address[9:0], table_value[15:0].
	input  wire logic [95:0] s_tdata,
	// From bit 0: opcode[1:0], table_select[1:0].
	input  wire logic [3:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// From bit 0: audio_byte[7:0].
	output logic [7:0]       m_tdata
);

	fsse_pkg::dp_cmd_t cmd;

	fsse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_opcode (s_tuser[1:0]),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// The datapath sees the beat fields unpacked; it acts on them only when
	// the sequencer flags an accepted beat.
	fsse_dp #(
		.LEVEL_LIMIT (LEVEL_LIMIT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.noise_a       (s_tdata[15:0]),
		.noise_b       (s_tdata[31:16]),
		.param_index   (s_tdata[37:32]),
		.param_value   (s_tdata[69:38]),
		.table_select  (s_tuser[3:2]),
		.table_address (s_tdata[79:70]),
		.table_value   (s_tdata[95:80]),
		.audio_byte    (m_tdata)
	);

endmodule
`default_nettype wire

// ----- rtl/fsse_checker.sv -----
// Port checker of the formant speech sample engine, bound to the top level.
// Depends on fsse_pkg.
`default_nettype none
module fsse_port_assert (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [3:0] s_tuser,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed while stalled");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[1:0] == fsse_pkg::OPC_SAMPLE |=> !s_tready)
		else $error("input ready right after a sample beat");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[1:0] != fsse_pkg::OPC_SAMPLE && !m_tvalid
		|=> s_tready && !m_tvalid)
		else $error("write beat produced output or stalled the input");

endmodule

bind formant_speech_sample_engine_core fsse_port_assert u_fsse_port_assert (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ----- test/fsse_checker.sv -----
// Port checker for the formant speech sample engine: predicts each audio byte
// from the accepted input beats and compares it with the output beats.
// Depends on fsse_pkg for opcodes, table selectors and state word numbers.
`timescale 1ns / 1ps
module fsse_checker #(
	parameter int LEVEL_LIMIT = 200
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [95:0] s_tdata,
	input  wire logic [3:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,
	output int               errors,
	output int               pending
);

	localparam int CURVE_DEPTH = 2 * LEVEL_LIMIT + 1;

	// Mirror of the engine state.
	logic [25:0] phase, phase_inc;
	logic [15:0] gain_a, gain_b, asp_neg, asp_pos, fric_neg, fric_pos, shape_gain, last_voiced;
	logic [31:0] voice_lvl, voice_slp;
	logic [15:0] hist1 [fsse_pkg::NUM_RES];
	logic [15:0] hist2 [fsse_pkg::NUM_RES];
	logic [31:0] a_lvl [fsse_pkg::NUM_RES];
	logic [31:0] a_slp [fsse_pkg::NUM_RES];
	logic [31:0] b_lvl [fsse_pkg::NUM_RES];
	logic [31:0] b_slp [fsse_pkg::NUM_RES];
	logic [15:0] wave_a [fsse_pkg::WAVE_DEPTH];
	logic [15:0] wave_b [fsse_pkg::WAVE_DEPTH];
	logic [7:0]  curve [CURVE_DEPTH];

	logic [7:0] audio_q[$];
	int         err_cnt;

	assign errors  = err_cnt;
	assign pending = audio_q.size();

	function automatic int s16(input logic [31:0] v);
		return int'(signed'(v[15:0]));
	endfunction

	function automatic int hi16(input logic [31:0] v);
		return s16(v >> 16);
	endfunction

	// Product of two signed words, a 16-bit slice taken from bit sh up.
	function automatic int mul_slice(input int a, input int b, input int sh);
		logic [31:0] p;
		p = a * b;
		return s16(p >> sh);
	endfunction

	// One two-pole resonator pass; sweeping ones advance their coefficients.
	function int resonate(input int k, input int x, input bit sweep);
		int d1, d2, y;
		d1 = s16(s16(hist1[k]) - x);
		d2 = s16(s16(hist2[k]) - x);
		y  = s16(x - mul_slice(d2, hi16(b_lvl[k]), 15) + mul_slice(d1, hi16(a_lvl[k]), 14));
		hist2[k] = hist1[k];
		hist1[k] = y[15:0];
		if (sweep) begin
			a_lvl[k] += a_slp[k];
			b_lvl[k] += b_slp[k];
		end
		return y;
	endfunction

	function void write_word(input logic [5:0] idx, input logic [31:0] v);
		int k, f;
		case (idx)
			fsse_pkg::PW_PHASE_ACC: phase       = v[25:0];
			fsse_pkg::PW_PHASE_INC: phase_inc   = v[25:0];
			fsse_pkg::PW_GAIN_A:    gain_a      = v[15:0];
			fsse_pkg::PW_GAIN_B:    gain_b      = v[15:0];
			fsse_pkg::PW_VOICE_LVL: voice_lvl   = v;
			fsse_pkg::PW_VOICE_SLP: voice_slp   = v;
			fsse_pkg::PW_ASP_NEG:   asp_neg     = v[15:0];
			fsse_pkg::PW_ASP_POS:   asp_pos     = v[15:0];
			fsse_pkg::PW_FRIC_NEG:  fric_neg    = v[15:0];
			fsse_pkg::PW_FRIC_POS:  fric_pos    = v[15:0];
			fsse_pkg::PW_SHAPE:     shape_gain  = v[15:0];
			fsse_pkg::PW_LAST:      last_voiced = v[15:0];
			default: begin
				if (idx < fsse_pkg::PW_RES_BASE
						+ fsse_pkg::FIELDS_PER_RES * fsse_pkg::NUM_RES) begin
					k = (idx - fsse_pkg::PW_RES_BASE) / fsse_pkg::FIELDS_PER_RES;
					f = (idx - fsse_pkg::PW_RES_BASE) % fsse_pkg::FIELDS_PER_RES;
					case (fsse_pkg::res_field_t'(f))
						fsse_pkg::RF_HIST1: hist1[k] = v[15:0];
						fsse_pkg::RF_HIST2: hist2[k] = v[15:0];
						fsse_pkg::RF_A_LVL: a_lvl[k] = v;
						fsse_pkg::RF_A_SLP: a_slp[k] = v;
						fsse_pkg::RF_B_LVL: b_lvl[k] = v;
						default:            b_slp[k] = v;
					endcase
				end
			end
		endcase
	endfunction

	// Full sample computation; returns the expected audio byte.
	function logic [7:0] synth_sample(input int na, input int nb);
		logic [9:0]  ix;
		logic [31:0] p;
		logic [15:0] shaped;
		int src, voiced, asp, fric, sig, noise, mixed, lvl;
		phase  = phase + phase_inc;
		ix     = phase[25:16];
		src    = s16(mul_slice(s16(wave_a[ix]), s16(gain_a), 15)
			+ mul_slice(s16(wave_b[ix]), s16(gain_b), 15));
		voiced = mul_slice(src, hi16(voice_lvl), 15);
		voice_lvl += voice_slp;
		asp  = voiced < 0 ? s16(asp_neg) : s16(asp_pos);
		fric = voiced < 0 ? s16(fric_neg) : s16(fric_pos);
		sig  = s16(2 * (voiced - s16(last_voiced)));
		last_voiced = voiced[15:0];

		sig = resonate(0, sig, 1'b1);
		sig = s16(sig + mul_slice(na, asp, 15));
		sig = resonate(1, sig, 1'b0);
		sig = resonate(2, sig, 1'b1);
		sig = resonate(3, sig, 1'b1);
		sig = resonate(4, sig, 1'b0);
		sig = resonate(5, sig, 1'b1);

		noise  = resonate(6, nb >>> 2, 1'b0);
		noise  = s16(mul_slice(noise, s16(shape_gain), 15) - (nb >>> 7));
		p      = noise * fric;
		shaped = {p[27:15], p[15:13]};
		mixed  = s16(sig + s16(shaped));
		lvl    = mixed >>> 5;
		if (lvl < -LEVEL_LIMIT) lvl = -LEVEL_LIMIT;
		if (lvl > LEVEL_LIMIT) lvl = LEVEL_LIMIT;
		return curve[lvl + LEVEL_LIMIT] + 8'd128;
	endfunction

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("%0t mismatch: %s audio_byte got %0d expected %0d", $realtime, what, got, want);
		err_cnt++;
	endtask

	initial begin
		err_cnt = 0;
		phase = '0; phase_inc = '0; gain_a = '0; gain_b = '0;
		asp_neg = '0; asp_pos = '0; fric_neg = '0; fric_pos = '0;
		shape_gain = '0; last_voiced = '0; voice_lvl = '0; voice_slp = '0;
		for (int k = 0; k < fsse_pkg::NUM_RES; k++) begin
			hist1[k] = '0; hist2[k] = '0;
			a_lvl[k] = '0; a_slp[k] = '0; b_lvl[k] = '0; b_slp[k] = '0;
		end
	end

	// Input side: accepted sample, parameter and table beats update the mirror state.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			case (s_tuser[1:0])
				fsse_pkg::OPC_SAMPLE: audio_q.push_back(synth_sample(s16(s_tdata[15:0]),
					s16(s_tdata[31:16])));
				fsse_pkg::OPC_PARAM: write_word(s_tdata[37:32], s_tdata[69:38]);
				fsse_pkg::OPC_TABLE: begin
					case (s_tuser[3:2])
						fsse_pkg::TSEL_WAVE_A: wave_a[s_tdata[79:70]] = s_tdata[95:80];
						fsse_pkg::TSEL_WAVE_B: wave_b[s_tdata[79:70]] = s_tdata[95:80];
						fsse_pkg::TSEL_CURVE:
							if (s_tdata[79:70] < CURVE_DEPTH)
								curve[s_tdata[79:70]] = s_tdata[87:80];
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Output side: each beat is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (audio_q.size() == 0)
				report("unexpected beat,", m_tdata, 8'd0);
			else if (m_tdata !== audio_q[0]) begin
				report("wrong", m_tdata, audio_q[0]);
				void'(audio_q.pop_front());
			end else
				void'(audio_q.pop_front());
		end
	end
endmodule

// ----- test/testbench.sv -----
// Top of the formant speech sample engine testbench: clock, reset, stimulus,
// output back-pressure and verdict. Depends on fsse_pkg, fsse_checker and the core.
`timescale 1ns / 1ps
module testbench;

	// Codes the engine ignores.
	localparam logic [1:0] OPC_IGNORED  = 2'd3;
	localparam logic [1:0] TSEL_IGNORED = 2'd3;
	localparam int         NUM_ITEMS    = 1550;
	localparam int         NUM_WORDS    = fsse_pkg::PW_RES_BASE
		+ fsse_pkg::FIELDS_PER_RES * fsse_pkg::NUM_RES;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	int          errors;
	int          pending;
	bit          hold_req;
	int          burst_left;
	int          sent;

	formant_speech_sample_engine_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	fsse_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	// Sends one beat and returns on the edge at which it is accepted. Between
	// bursts the valid drops for a random gap three times in four.
	task automatic send_beat(input logic [1:0] op, input logic [1:0] tsel, input logic [95:0] d);
		s_tvalid <= 1'b1;
		s_tuser  <= {tsel, op};
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 30);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	endtask

	function automatic logic [95:0] noise_bits();
		return {$urandom, $urandom, $urandom};
	endfunction

	task automatic sample(input logic [15:0] na, input logic [15:0] nb);
		logic [95:0] d;
		d = noise_bits();
		d[31:0] = {nb, na};
		send_beat(fsse_pkg::OPC_SAMPLE, 2'($urandom), d);
	endtask

	task automatic param(input logic [5:0] idx, input logic [31:0] val);
		logic [95:0] d;
		d = noise_bits();
		d[69:32] = {val, idx};
		send_beat(fsse_pkg::OPC_PARAM, 2'($urandom), d);
	endtask

	task automatic table_write(input logic [1:0] tsel, input logic [9:0] addr,
		input logic [15:0] val);
		logic [95:0] d;
		d = noise_bits();
		d[95:70] = {val, addr};
		send_beat(fsse_pkg::OPC_TABLE, tsel, d);
	endtask

	// Noise values lean on the extremes now and then.
	function automatic logic [15:0] rand_noise();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// Receiver: stretches of steady acceptance or random stalls, plus one long
	// hold-off when the stimulus asks for it.
	initial begin
		int n;
		int mode;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				n = $urandom_range(1, 40);
				mode = $urandom_range(0, 2);
				repeat (n) begin
					m_tready <= (mode == 0) ? 1'b1 : 1'($urandom_range(0, 1));
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		int r;
		logic [5:0]  idx;
		logic [31:0] val;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		hold_req   = 1'b0;
		burst_left = 0;
		sent       = 0;
		arst_n     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every table entry is written before the first sample can read it.
		for (int a = 0; a < fsse_pkg::WAVE_DEPTH; a++) begin
			table_write(fsse_pkg::TSEL_WAVE_A, 10'(a), (a == 0) ? 16'h8000 : 16'($urandom));
			table_write(fsse_pkg::TSEL_WAVE_B, 10'(a), (a == 1) ? 16'h7fff : 16'($urandom));
		end
		for (int a = 0; a <= 400; a++)
			table_write(fsse_pkg::TSEL_CURVE, 10'(a), 16'($urandom));

		// Directed part: a sample from the cleared state, extreme gains and
		// noise, the beats the engine must ignore, then edge table and phase writes.
		sample(16'h0000, 16'h0000);
		param(fsse_pkg::PW_GAIN_A, 32'h0000_7fff);
		param(fsse_pkg::PW_GAIN_B, 32'hffff_8000);
		param(fsse_pkg::PW_VOICE_LVL, 32'h7fff_0000);
		param(fsse_pkg::PW_VOICE_SLP, 32'hffff_ffff);
		param(fsse_pkg::PW_PHASE_INC, 32'hffff_ffff);
		param(fsse_pkg::PW_ASP_NEG, 32'h0000_8000);
		param(fsse_pkg::PW_ASP_POS, 32'h0000_7fff);
		param(fsse_pkg::PW_FRIC_NEG, 32'h0000_8000);
		param(fsse_pkg::PW_FRIC_POS, 32'h0000_7fff);
		param(fsse_pkg::PW_SHAPE, 32'h0000_7fff);
		param(fsse_pkg::PW_LAST, 32'h0001_8000);
		param(6'(fsse_pkg::PW_RES_BASE), 32'hffff_8000);
		param(6'(NUM_WORDS - 1), 32'hffff_ffff);
		sample(16'h8000, 16'h8000);
		sample(16'h7fff, 16'h7fff);
		sample(16'hffff, 16'h0001);
		param(6'd63, 32'h1234_5678);
		send_beat(OPC_IGNORED, fsse_pkg::TSEL_CURVE, noise_bits());
		table_write(TSEL_IGNORED, 10'd5, 16'h1234);
		table_write(fsse_pkg::TSEL_CURVE, 10'd1023, 16'h00aa);
		table_write(fsse_pkg::TSEL_CURVE, 10'd400, 16'hffff);
		param(fsse_pkg::PW_PHASE_ACC, 32'h03ff_ffff);
		sample(rand_noise(), rand_noise());

		// Random part: mostly samples, mixed with state word and table writes.
		while (sent < NUM_ITEMS) begin
			if (sent == 500) hold_req = 1'b1;
			if (sent == 1000) begin
				s_tvalid <= 1'b0;
				wait (pending == 0);
				@(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 65) begin
				sample(rand_noise(), rand_noise());
				sent++;
			end else if (r < 85) begin
				idx = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(NUM_WORDS, 63))
					: 6'($urandom_range(0, NUM_WORDS - 1));
				case ($urandom_range(0, 3))
					0: val = 32'(signed'(16'($urandom))) <<< $urandom_range(0, 12);
					1: val = {16'($urandom_range(0, 16'h7fff)), 16'($urandom)};
					default: val = $urandom;
				endcase
				param(idx, val);
				if (idx < NUM_WORDS) sent++;
			end else if (r < 96) begin
				idx = 6'($urandom_range(0, 3));
				table_write(idx[1:0], 10'($urandom), 16'($urandom));
				if (idx[1:0] != TSEL_IGNORED) sent++;
			end else
				send_beat(OPC_IGNORED, 2'($urandom), noise_bits());
		end
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/fsse_pkg.sv
rtl/fsse_ctrl.sv
rtl/fsse_dp.sv
rtl/formant_speech_sample_engine_core.sv
rtl/fsse_checker.sv
test/fsse_checker.sv
test/testbench.sv
